// ----- src/led_running_bar_animator_defines.svh -----
// ----------------------------------------------------------------------------
// led_running_bar_animator_defines
// Assertion macros shared by the animator modules.
// ----------------------------------------------------------------------------
`ifndef LED_RUNNING_BAR_ANIMATOR_DEFINES_SVH
`define LED_RUNNING_BAR_ANIMATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define LRBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LRBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lrba_pkg.sv -----
// ----------------------------------------------------------------------------
// lrba_pkg
// Types, constants and the bump shape table of the running bar animator.
// ----------------------------------------------------------------------------
package lrba_pkg;

    localparam int LAMP_W     = 6;   // lamp index width
    localparam int LEVEL_W    = 8;
    localparam int STEP_W     = 12;
    localparam int POS_W      = 14;  // 6.8 position, 6 integer bits
    localparam int RING_W     = 15;  // holds NUM_LAMPS*256 itself
    localparam int BUMP_IDX_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam int POS_INIT    = 50 * 256;
    localparam int START2_INIT = 25;

    localparam logic [STEP_W-1:0]  STEP0_RESET = 12'd200;
    localparam logic [STEP_W-1:0]  STEP1_RESET = 12'd150;
    localparam logic [STEP_W-1:0]  STEP2_RESET = 12'd175;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'hff;
    localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 8'h00;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_WHITE = 2'd1,
        MODE_BARS  = 2'd2,
        MODE_PAUSE = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_STEP0 = 2'd1,
        CFG_STEP1 = 2'd2,
        CFG_STEP2 = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EMIT   = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    typedef struct packed {
        logic  load;    // start of frame: clear lamp counter, load bump offsets, latch mode
        logic  emit;    // push one lamp into the output register
        logic  reduce;  // fold steps into the ring
        logic  update;  // move positions and starts
        t_mode mode;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic last_lamp;
    } t_sts;

    function automatic logic [LEVEL_W-1:0] bump_shape(input logic [BUMP_IDX_W-1:0] idx);
        logic [LEVEL_W-1:0] v;
        unique case (idx)
            4'd0:    v = 8'h20;
            4'd1:    v = 8'h70;
            4'd2:    v = 8'ha0;
            4'd3:    v = 8'hb0;
            4'd4:    v = 8'hd0;
            4'd5:    v = 8'hf0;
            4'd6:    v = 8'hff;
            4'd7:    v = 8'hff;
            4'd8:    v = 8'hf0;
            4'd9:    v = 8'hd0;
            4'd10:   v = 8'hb0;
            4'd11:   v = 8'ha0;
            4'd12:   v = 8'h70;
            4'd13:   v = 8'h20;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ----- src/lrba_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrba_ctrl
// Frame sequencer: takes requests, walks the lamps, then in bars mode moves the bars.
// ----------------------------------------------------------------------------
`include "led_running_bar_animator_defines.svh"

module lrba_ctrl
    import lrba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  logic  i_frame,
    input  t_mode i_mode,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_bars,  n_bars;
    logic   w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state      = r_state;
        n_bars       = r_bars;
        o_cmd.load   = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.reduce = 1'b0;
        o_cmd.update = 1'b0;
        o_cmd.mode   = i_mode;
        unique case (r_state)
            ST_IDLE: begin
                // a request in pause mode or a zero tick is taken and dropped
                if (w_accept && i_frame && (i_mode != MODE_PAUSE)) begin
                    o_cmd.load = 1'b1;
                    n_bars     = (i_mode == MODE_BARS);
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_lamp) begin
                        n_state = r_bars ? ST_REDUCE : ST_IDLE;
                    end
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_state      = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bars  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bars  <= n_bars;
        end
    end

    `LRBA_ASSERT_IMPL(a_update_after_reduce, i_clk, i_rst_n, r_state == ST_UPDATE, $past(r_state) == ST_REDUCE, "update without reduce")
    `LRBA_ASSERT_NEXT(a_update_to_idle, i_clk, i_rst_n, r_state == ST_UPDATE, r_state == ST_IDLE, "update did not return to idle")
    `LRBA_ASSERT_NEXT(a_drop_stays_idle, i_clk, i_rst_n, w_accept && (!i_frame || (i_mode == MODE_PAUSE)), r_state == ST_IDLE, "dropped request started a frame")

endmodule

// ----- src/lrba_dp.sv -----
// ----------------------------------------------------------------------------
// lrba_dp
// Lamp and bump offset counters, output register and position arithmetic.
// ----------------------------------------------------------------------------
`include "led_running_bar_animator_defines.svh"

module lrba_dp
    import lrba_pkg::*;
#(
    parameter int NUM_LAMPS = 64,
    parameter int BUMP_LEN  = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [STEP_W-1:0]     i_step0,
    input  logic [STEP_W-1:0]     i_step1,
    input  logic [STEP_W-1:0]     i_step2,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    localparam logic [LAMP_W-1:0] LAST_LAMP    = LAMP_W'(NUM_LAMPS - 1);
    localparam logic [LAMP_W-1:0] LAMP_COUNT   = LAMP_W'(NUM_LAMPS);  // 64 wraps to 0
    localparam logic [LAMP_W-1:0] BUMP_END     = LAMP_W'(BUMP_LEN);
    localparam logic [RING_W-1:0] RING         = RING_W'(NUM_LAMPS * 256);
    localparam logic [POS_W-1:0]  POS_RESET    = POS_W'(POS_INIT % (NUM_LAMPS * 256));
    localparam logic [LAMP_W-1:0] START2_RESET = LAMP_W'(START2_INIT % NUM_LAMPS);

    logic [LAMP_W-1:0]     r_lamp;
    logic [LAMP_W-1:0]     r_off   [3];
    logic [LAMP_W-1:0]     r_start [3];
    logic [POS_W-1:0]      r_pos   [3];
    logic [POS_W-1:0]      r_stepr [3];
    t_mode                 r_kind;
    logic                  r_tvalid;
    logic [OUT_DATA_W-1:0] r_tdata;
    logic                  r_tlast;

    logic [STEP_W-1:0]  w_step  [3];
    logic [POS_W-1:0]   n_stepr [3];
    logic [POS_W-1:0]   n_pos   [3];
    logic [LAMP_W-1:0]  n_off0  [3];
    logic [LEVEL_W-1:0] w_lvl   [3];
    logic [RING_W-1:0]  w_s     [3];
    logic [RING_W-1:0]  w_sum   [3];
    logic [RING_W-1:0]  w_fwd   [3];
    logic [RING_W-1:0]  w_bwd;

    assign w_step[0] = i_step0;
    assign w_step[1] = i_step1;
    assign w_step[2] = i_step2;

    assign o_sts.slot_free = !r_tvalid || i_m_tready;
    assign o_sts.last_lamp = (r_lamp == LAST_LAMP);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // offset of lamp 0 inside the bump: (0 - start) mod NUM_LAMPS
            n_off0[i] = (r_start[i] == '0) ? '0 : LAMP_COUNT - r_start[i];

            unique case (r_kind)
                MODE_BARS:  w_lvl[i] = (r_off[i] < BUMP_END) ?
                                       bump_shape(r_off[i][BUMP_IDX_W-1:0]) : LEVEL_NONE;
                MODE_WHITE: w_lvl[i] = LEVEL_FULL;
                default:    w_lvl[i] = LEVEL_NONE;
            endcase

            // a step never exceeds twice the ring, one subtract folds it
            w_s[i]     = RING_W'(w_step[i]);
            n_stepr[i] = (w_s[i] >= RING) ? POS_W'(w_s[i] - RING) : POS_W'(w_s[i]);

            w_sum[i] = RING_W'(r_pos[i]) + RING_W'(r_stepr[i]);
            w_fwd[i] = (w_sum[i] >= RING) ? (w_sum[i] - RING) : w_sum[i];
        end

        // channel 2 runs backward; borrow is repaired by one ring
        w_bwd = RING_W'(r_pos[2]) - RING_W'(r_stepr[2]);
        if (r_pos[2] < r_stepr[2]) begin
            w_bwd = w_bwd + RING;
        end

        n_pos[0] = POS_W'(w_fwd[0]);
        n_pos[1] = POS_W'(w_fwd[1]);
        n_pos[2] = POS_W'(w_bwd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid   <= 1'b0;
            r_pos[0]   <= POS_RESET;
            r_pos[1]   <= POS_RESET;
            r_pos[2]   <= POS_RESET;
            r_start[0] <= '0;
            r_start[1] <= '0;
            r_start[2] <= START2_RESET;
        end else begin
            if (i_cmd.emit) begin
                r_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_tvalid <= 1'b0;
            end
            if (i_cmd.update) begin
                for (int i = 0; i < 3; i++) begin
                    r_pos[i]   <= n_pos[i];
                    r_start[i] <= n_pos[i][POS_W-1:8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lamp <= '0;
            r_kind <= i_cmd.mode;
            for (int i = 0; i < 3; i++) begin
                r_off[i] <= n_off0[i];
            end
        end else if (i_cmd.emit) begin
            r_lamp  <= r_lamp + 1'b1;
            r_tdata <= {2'b00, w_lvl[2], w_lvl[1], w_lvl[0], r_lamp};
            r_tlast <= (r_lamp == LAST_LAMP);
            for (int i = 0; i < 3; i++) begin
                r_off[i] <= (r_off[i] == LAST_LAMP) ? '0 : r_off[i] + 1'b1;
            end
        end
        if (i_cmd.reduce) begin
            for (int i = 0; i < 3; i++) begin
                r_stepr[i] <= n_stepr[i];
            end
        end
    end

    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;

    `LRBA_ASSERT_IMPL(a_last_on_final_lamp, i_clk, i_rst_n, r_tvalid && r_tlast, r_tdata[LAMP_W-1:0] == LAST_LAMP, "tlast on wrong lamp")
    `LRBA_ASSERT_IMPL(a_pos0_in_ring, i_clk, i_rst_n, 1'b1, RING_W'(r_pos[0]) < RING, "pos0 left the ring")
    `LRBA_ASSERT_IMPL(a_pos2_in_ring, i_clk, i_rst_n, 1'b1, RING_W'(r_pos[2]) < RING, "pos2 left the ring")

endmodule

// ----- src/led_running_bar_animator.sv -----
// ----------------------------------------------------------------------------
// led_running_bar_animator
// One colour beat per lamp for each frame tick outside pause mode; three running bars in mode 2.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat                                   Accepted when
// s_axis    in   tdata[0] frame_request                 tvalid & tready
// m_axis    out  tdata lamp, red, green, blue; tlast    tvalid & tready
// cfg       in   idx, data (mode, three steps)          wen
//
// A request is taken only while idle, then one lamp leaves per cycle while the
// sink keeps tready high, NUM_LAMPS lamps a frame as the lamp walk sets them.
// After a bars frame, ST_REDUCE folds the steps and ST_UPDATE moves the bars.
// A stalled sink holds the walk; the output register keeps the beat it has.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module led_running_bar_animator
    import lrba_pkg::*;
#(
    parameter int NUM_LAMPS = 64,
    parameter int BUMP_LEN  = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [0] frame_request
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [5:0] lamp_index, [13:6] chan0_level,
                                                    // [21:14] chan1_level, [29:22] chan2_level
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [STEP_W-1:0]     i_cfg_data
);

    t_mode             r_mode;
    logic [STEP_W-1:0] r_step0;
    logic [STEP_W-1:0] r_step1;
    logic [STEP_W-1:0] r_step2;
    t_cmd              w_cmd;
    t_sts              w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BARS;
            r_step0 <= STEP0_RESET;
            r_step1 <= STEP1_RESET;
            r_step2 <= STEP2_RESET;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[1:0]);
                CFG_STEP0: r_step0 <= i_cfg_data;
                CFG_STEP1: r_step1 <= i_cfg_data;
                CFG_STEP2: r_step2 <= i_cfg_data;
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    lrba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_frame    (i_s_axis_tdata[0]),
        .i_mode     (r_mode),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lrba_dp #(
        .NUM_LAMPS (NUM_LAMPS),
        .BUMP_LEN  (BUMP_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_step0    (r_step0),
        .i_step1    (r_step1),
        .i_step2    (r_step2),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule
